// ===== hw/rtl/rans_pkg.sv =====
// Shared types and constants for the rANS symbol encoder.
// Used by rans_ctrl, rans_dp, the top level and the checker; no dependencies.
package rans_pkg;

  localparam int unsigned STATE_W  = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned FREQ_W   = 17;
  localparam int unsigned LR_W     = 5;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned TBL_DEPTH = 256;
  localparam int unsigned TBL_AW   = $clog2(TBL_DEPTH);
  localparam int unsigned LIM_W    = HALF_W + FREQ_W;

  // Coder state after reset and after a flush.
  localparam logic [HALF_W-1:0] ANS_TOP = 32'd8388608;

  localparam logic [LR_W-1:0] LR_RESET = 5'd12;
  localparam logic [LR_W-1:0] LR_MIN   = 5'd8;
  localparam logic [LR_W-1:0] LR_MAX   = 5'd16;

  // Radix-2 divider: one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = STATE_W;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  // Item modes.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_wr;        // write both table entries
    logic tbl_rd;        // read the symbol's entry
    logic lim_load;      // hold freq, cum and the renormalization limit
    logic renorm_emit;   // emit the low word and shift the state
    logic div_start;     // load the divider
    logic div_step;      // advance the divider by one bit
    logic state_update;  // write the new coder state
    logic flush_emit;    // emit the final state and return to ANS_TOP
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic freq_zero;
    logic renorm_need;
    logic out_full;
    logic div_last;
  } sts_t;

endpackage

// ===== hw/rtl/rans_ctrl.sv =====
// Controller of the rANS symbol encoder: sequences load, encode and flush items.
// Depends on rans_pkg for the mode codes and the command/status structs.
module rans_ctrl
  import rans_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_RENORM,
    S_DIVIDE,
    S_UPDATE,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_LOAD: cmd.tbl_wr = 1'b1;
            MODE_ENCODE: begin
              cmd.tbl_rd = 1'b1;
              state_next = S_LOOKUP;
            end
            MODE_FLUSH: state_next = S_FLUSH;
            default: ;  // unused mode: drop the item
          endcase
        end
      end
      S_LOOKUP: begin
        if (sts.freq_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.lim_load = 1'b1;
          state_next   = S_RENORM;
        end
      end
      S_RENORM: begin
        if (sts.renorm_need) begin
          if (!sts.out_full) begin
            cmd.renorm_emit = 1'b1;
            cmd.div_start   = 1'b1;
            state_next      = S_DIVIDE;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.state_update = 1'b1;
        state_next       = S_IDLE;
      end
      S_FLUSH: begin
        if (!sts.out_full) begin
          cmd.flush_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/rans_dp.sv =====
// Datapath of the rANS symbol encoder: symbol tables, coder state, limit
// multiplier, radix-2 divider and output register. Depends on rans_pkg.
module rans_dp
  import rans_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [SYM_W-1:0]    symbol,
  input  logic [FREQ_W-1:0]   freq_value,
  input  logic [FREQ_W-1:0]   cum_value,
  input  logic                cfg_wr,
  input  logic [LR_W-1:0]     cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATE_W-1:0]  word,
  output logic                is_final
);

  // Symbol table: freq in the upper half, cum in the lower half.
  logic [2*FREQ_W-1:0] tbl_mem [TBL_DEPTH];
  logic [2*FREQ_W-1:0] tbl_rdata;

  logic [LR_W-1:0]    log_range;
  logic [LR_W-1:0]    lr_eff;
  logic [STATE_W-1:0] coder_state;
  logic [FREQ_W-1:0]  freq;
  logic [FREQ_W-1:0]  cum;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   lim_next;
  logic [HALF_W-1:0]  top_shifted;

  logic [STATE_W-1:0] div_q;
  logic [FREQ_W-1:0]  div_rem;
  logic [DIV_CW-1:0]  div_cnt;
  logic [FREQ_W:0]    trial;
  logic               trial_ge;
  logic [STATE_W-1:0] st_new;
  logic [FREQ_W-1:0]  rd_freq;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[symbol] <= {freq_value, cum_value};
    end
    if (cmd.tbl_rd) begin
      tbl_rdata <= tbl_mem[symbol];
    end
  end

  assign rd_freq = tbl_rdata[2*FREQ_W-1:FREQ_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      log_range <= LR_RESET;
    end else if (cfg_wr) begin
      log_range <= cfg_data;
    end
  end

  // Clamp the shift to its meaningful range.
  always_comb begin
    if (log_range < LR_MIN) begin
      lr_eff = LR_MIN;
    end else if (log_range > LR_MAX) begin
      lr_eff = LR_MAX;
    end else begin
      lr_eff = log_range;
    end
  end

  assign top_shifted = ANS_TOP >> lr_eff;
  assign lim_next    = LIM_W'(top_shifted) * LIM_W'(rd_freq);

  always_ff @(posedge clk) begin
    if (cmd.lim_load) begin
      freq <= rd_freq;
      cum  <= tbl_rdata[FREQ_W-1:0];
      lim  <= lim_next;
    end
  end

  // Restoring divider: the dividend shifts out of div_q as quotient bits shift in.
  assign trial    = {div_rem, div_q[STATE_W-1]};
  assign trial_ge = (trial >= {1'b0, freq});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= cmd.renorm_emit ? (coder_state >> HALF_W) : coder_state;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[STATE_W-2:0], trial_ge};
      div_rem <= trial_ge ? FREQ_W'(trial - {1'b0, freq}) : trial[FREQ_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign st_new = (div_q << lr_eff) + STATE_W'(div_rem) + STATE_W'(cum);

  always_ff @(posedge clk) begin
    if (rst) begin
      coder_state <= STATE_W'(ANS_TOP);
    end else if (cmd.state_update) begin
      coder_state <= st_new;
    end else if (cmd.flush_emit) begin
      coder_state <= STATE_W'(ANS_TOP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.renorm_emit || cmd.flush_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.renorm_emit) begin
      word     <= {{HALF_W{1'b0}}, coder_state[HALF_W-1:0]};
      is_final <= 1'b0;
    end else if (cmd.flush_emit) begin
      word     <= coder_state;
      is_final <= 1'b1;
    end
  end

  assign sts.freq_zero   = (rd_freq == '0);
  assign sts.renorm_need = (LIM_W'(coder_state[STATE_W-1:HALF_W]) >= lim);
  assign sts.out_full    = out_valid && !out_ready;
  assign sts.div_last    = (div_cnt == DIV_CW'(DIV_STEPS - 1));

endmodule

// ===== hw/rtl/rans_symbol_encoder.sv =====
// Top level of the rANS symbol encoder: joins the controller and the datapath.
// Depends on rans_pkg, rans_ctrl and rans_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: mode, symbol, freq_value,
//   cum_value. A load item writes the symbol's frequency and cumulative
//   frequency and finishes in its accept cycle. An encode item reads its table
//   entry in the accept cycle, then holds in_ready low through one limit
//   multiply, one renormalization check (which waits while it must emit into
//   a full output register), the radix-2 divider and one state update.
//   A zero-frequency encode ends after its lookup; a flush ends once it emits its word.
//   Output channel (out_valid/out_ready) carries word and is_final. An encode
//   item may emit one 32-bit renormalization word; a flush always emits the
//   64-bit final state with is_final set. The result sits in an output
//   register, so new items are accepted while it waits; only an item that
//   must emit while that register is still full waits for the receiver.
//   Config channel (cfg_valid/cfg_ready) writes log_range; it is always ready
//   and must only be used while the block is idle.
//   Reset clears the controller, drops any pending result, sets the coder state
//   to ANS_TOP and log_range to 12. The symbol tables are not cleared.
module rans_symbol_encoder
  import rans_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [SYM_W-1:0]    symbol,
  input  logic [FREQ_W-1:0]   freq_value,
  input  logic [FREQ_W-1:0]   cum_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATE_W-1:0]  word,
  output logic                is_final,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LR_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // The config register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  rans_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  rans_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .symbol     (symbol),
    .freq_value (freq_value),
    .cum_value  (cum_value),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word       (word),
    .is_final   (is_final)
  );

endmodule

// ===== hw/rtl/rans_sva.sv =====
// Port-level checker for the rANS symbol encoder, bound to the top level.
// Depends on rans_pkg and rans_symbol_encoder.
module rans_sva
  import rans_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          mode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATE_W-1:0]  word,
  input logic                is_final
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word) && $stable(is_final))
    else $error("stalled result changed");

  // A renormalization word carries only 32 bits.
  a_renorm_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_final |-> word[STATE_W-1:HALF_W] == '0)
    else $error("renormalization word has upper bits set");

  // An accepted encode or flush item leaves the block busy: in_ready drops.
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_ENCODE || mode == MODE_FLUSH) |=> !in_ready)
    else $error("block ready right after an encode or flush item");

  // Reset drops any pending result and leaves the block ready.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or block busy after reset");

endmodule

bind rans_symbol_encoder rans_sva u_sva (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .word      (word),
  .is_final  (is_final)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for rans_symbol_encoder: table loads, symbol encodes and flushes
// under several log_range settings and handshake pressures, checked word by word.
// Depends on rans_pkg and the rans_symbol_encoder RTL; reads no files.
module tb_top;
  import rans_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 80;    // one encode item plus margin
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;

  typedef struct packed {
    logic [STATE_W-1:0] word;
    logic               is_final;
  } coded_word_t;

  // Shadow of the coder: tables, state and log_range, plus the words still owed.
  class coded_word_tracker;
    logic [FREQ_W-1:0]  freq_tbl [TBL_DEPTH];
    logic [FREQ_W-1:0]  cum_tbl [TBL_DEPTH];
    logic [STATE_W-1:0] coder_st;
    logic [LR_W-1:0]    log_range;
    coded_word_t        owed_words [$];
    int unsigned        bad_fields;

    function new();
      coder_st   = STATE_W'(ANS_TOP);
      log_range  = LR_RESET;
      bad_fields = 0;
    endfunction

    // Advance the shadow by one accepted item and queue the word it owes, if any.
    function void absorb_item(logic [1:0] md, logic [SYM_W-1:0] sym,
                              logic [FREQ_W-1:0] fv, logic [FREQ_W-1:0] cv);
      logic [STATE_W-1:0] f;
      logic [STATE_W-1:0] st;
      logic [STATE_W-1:0] lim;
      logic [LR_W-1:0]    lr;
      case (md)
        MODE_LOAD: begin
          freq_tbl[sym] = fv;
          cum_tbl[sym]  = cv;
        end
        MODE_ENCODE: begin
          f = STATE_W'(freq_tbl[sym]);
          // Zero frequency: drop the item, state untouched.
          if (f != '0) begin
            lr = log_range;
            if (lr < LR_MIN) lr = LR_MIN;
            if (lr > LR_MAX) lr = LR_MAX;
            lim = (STATE_W'(ANS_TOP) >> lr) * f;
            st  = coder_st;
            if ((st >> HALF_W) >= lim) begin
              owed_words.push_back('{word: {{HALF_W{1'b0}}, st[HALF_W-1:0]}, is_final: 1'b0});
              st = st >> HALF_W;
            end
            // Wraps modulo 2^64 when tables and log_range disagree.
            coder_st = ((st / f) << lr) + (st % f) + STATE_W'(cum_tbl[sym]);
          end
        end
        MODE_FLUSH: begin
          owed_words.push_back('{word: coder_st, is_final: 1'b1});
          coder_st = STATE_W'(ANS_TOP);
        end
        default: ;  // unused mode: no word, no change
      endcase
    endfunction

    function void match_word(logic [STATE_W-1:0] w, logic fin);
      coded_word_t want;
      if (owed_words.size() == 0) begin
        $error("word: expected none, actual %h (is_final %0b)", w, fin);
        bad_fields++;
        return;
      end
      want = owed_words.pop_front();
      if (w !== want.word) begin
        $error("word: expected %h, actual %h", want.word, w);
        bad_fields++;
      end
      if (fin !== want.is_final) begin
        $error("is_final: expected %0b, actual %0b", want.is_final, fin);
        bad_fields++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = MODE_LOAD;
  logic [SYM_W-1:0]   symbol = '0;
  logic [FREQ_W-1:0]  freq_value = '0;
  logic [FREQ_W-1:0]  cum_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STATE_W-1:0] word;
  logic               is_final;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LR_W-1:0]    cfg_data = LR_RESET;

  coded_word_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          sym_loaded [TBL_DEPTH];
  logic [SYM_W-1:0] alphabet [$];

  rans_symbol_encoder DUT (.*);

  always #6 clk = ~clk;

  // Hard stop: covers a hung handshake or a word that never arrives.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random, check every word taken at this edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) tracker.match_word(word, is_final);
  end

  // Offer one item, idling first at random; hold valid and payload until taken.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(input logic [1:0] md, input logic [SYM_W-1:0] sym,
                           input logic [FREQ_W-1:0] fv, input logic [FREQ_W-1:0] cv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    mode       <= md;
    symbol     <= sym;
    freq_value <= fv;
    cum_value  <= cv;
    do @(posedge clk); while (!in_ready);
    tracker.absorb_item(md, sym, fv, cv);
    if (md == MODE_LOAD) sym_loaded[sym] = 1'b1;
    items_sent++;
  endtask

  // Drop valid, wait for every owed word, then let a silent encode finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_log_range(input logic [LR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.log_range = v;
  endtask

  // Load a fresh alphabet whose frequencies sum to 2^lr, cum as the running prefix sum.
  task automatic load_alphabet(input int unsigned lr);
    bit               taken [TBL_DEPTH];
    int unsigned      n;
    int unsigned      left;
    int unsigned      extra;
    int unsigned      cum;
    logic [SYM_W-1:0] s;
    alphabet.delete();
    n    = $urandom_range(1, 20);
    left = (1 << lr) - n;
    cum  = 0;
    for (int i = 0; i < n; i++) begin
      do s = SYM_W'($urandom); while (taken[s]);
      taken[s] = 1'b1;
      extra = (i == n - 1) ? left : $urandom_range(0, left);
      left -= extra;
      send_item(MODE_LOAD, s, FREQ_W'(1 + extra), FREQ_W'(cum));
      alphabet.push_back(s);
      cum += 1 + extra;
    end
  endtask

  // Encode a random message over the current alphabet and close it with a flush.
  // Unused payload fields carry random bits.
  task automatic encode_message(input int unsigned n);
    for (int i = 0; i < n; i++)
      send_item(MODE_ENCODE, alphabet[$urandom_range(alphabet.size() - 1)],
                FREQ_W'($urandom), FREQ_W'($urandom));
    send_item(MODE_FLUSH, SYM_W'($urandom), FREQ_W'($urandom), FREQ_W'($urandom));
  endtask

  // Off-protocol traffic: unused mode, stray loads with any 17-bit value, lone
  // encodes and flushes, and encodes of a symbol just loaded with zero frequency.
  task automatic send_noise();
    logic [SYM_W-1:0] s;
    s = SYM_W'($urandom);
    case ($urandom_range(4))
      0: send_item(MODE_UNUSED, s, FREQ_W'($urandom), FREQ_W'($urandom));
      1: send_item(MODE_LOAD, s, FREQ_W'($urandom), FREQ_W'($urandom));
      2: begin
        // Never read a table entry that was not written.
        while (!sym_loaded[s]) s = SYM_W'($urandom);
        send_item(MODE_ENCODE, s, FREQ_W'($urandom), FREQ_W'($urandom));
      end
      3: send_item(MODE_FLUSH, s, FREQ_W'($urandom), FREQ_W'($urandom));
      default: begin
        send_item(MODE_LOAD, s, '0, FREQ_W'($urandom));
        send_item(MODE_ENCODE, s, FREQ_W'($urandom), FREQ_W'($urandom));
      end
    endcase
  endtask

  // One phase: set pressure and log_range while idle, mostly well-formed messages.
  task automatic run_phase(input logic [LR_W-1:0] lr_cfg, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    int unsigned lr_eff;
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_log_range(lr_cfg);
    lr_eff  = (lr_cfg < LR_MIN) ? LR_MIN : (lr_cfg > LR_MAX) ? LR_MAX : lr_cfg;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        load_alphabet(lr_eff);
        repeat ($urandom_range(1, 3)) encode_message($urandom_range(8, 40));
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset log_range of 12.
    send_item(MODE_LOAD, 8'd0, 17'd1, 17'd0);                // smallest frequency
    send_item(MODE_LOAD, 8'd255, 17'h1FFFF, 17'h1FFFF);      // all ones
    send_item(MODE_LOAD, 8'd128, 17'd65536, 17'd65536);      // top of the range
    send_item(MODE_LOAD, 8'd7, 17'd0, 17'd0);                // zero frequency
    send_item(MODE_ENCODE, 8'd7, 17'd0, 17'd0);              // ignored
    send_item(MODE_UNUSED, 8'hFF, 17'h1FFFF, 17'h1FFFF);     // ignored
    send_item(MODE_FLUSH, 8'd0, 17'd0, 17'd0);               // flush straight from reset
    // Frequency one multiplies the state by 2^12 per symbol: renormalize on the third.
    repeat (6) send_item(MODE_ENCODE, 8'd0, 17'h1FFFF, 17'h1FFFF);
    send_item(MODE_ENCODE, 8'd255, 17'd0, 17'd0);
    send_item(MODE_ENCODE, 8'd128, 17'd0, 17'd0);
    send_item(MODE_FLUSH, 8'hFF, 17'h1FFFF, 17'h1FFFF);
    // Matching two-symbol alphabet for log_range 12.
    send_item(MODE_LOAD, 8'd1, 17'd4095, 17'd1);
    send_item(MODE_ENCODE, 8'd1, 17'd0, 17'd0);
    send_item(MODE_ENCODE, 8'd0, 17'd0, 17'd0);
    send_item(MODE_ENCODE, 8'd1, 17'd0, 17'd0);
    send_item(MODE_ENCODE, 8'd1, 17'd0, 17'd0);
    send_item(MODE_FLUSH, 8'd0, 17'd0, 17'd0);
    send_item(MODE_FLUSH, 8'd0, 17'd0, 17'd0);               // back-to-back flush
    drain();

    run_phase(5'd8, 0, 0);
    run_phase(5'd16, 83, 0);
    run_phase(5'd0, 0, 83);                                  // clamps to 8
    run_phase(5'd31, 31, 31);                                // clamps to 16
    run_phase(LR_RESET, 83, 83);
    run_phase(LR_W'($urandom_range(9, 15)), 0, 0);

    if (tracker.bad_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
